[hdl/laser_scan_box_filter_core_macros.svh]
// Assertion macros shared by the box filter RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef LASER_SCAN_BOX_FILTER_CORE_MACROS_SVH
`define LASER_SCAN_BOX_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// condition must hold at every clock edge out of reset
`define LSBF_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define LSBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LSBF_ASSERT_NOW(lbl, cond, msg)
`define LSBF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/lsbf_pkg.sv]
// Shared widths, types, constants and the CORDIC angle table of the box filter.
// No dependencies.
package lsbf_pkg;

	localparam int IDX_W     = 12;
	localparam int RNG_W     = 16;
	localparam int ANG_W     = 16;
	localparam int BOX_W     = 17;
	localparam int CFG_W     = 17;
	localparam int FRAC_BITS = 30;
	localparam int PHASE_W   = 32;
	localparam int MAG_W     = RNG_W + FRAC_BITS;
	localparam int XW        = 48;
	localparam int ZW        = 34;
	localparam int NROT      = 24;

	localparam logic [FRAC_BITS-1:0] GAIN_Q30 = 30'd652032874;

	// atan(2^-i) in units of 2^32 per turn
	localparam logic signed [ZW-1:0] ATAN_TAB [NROT] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458908, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679839,  34'sd5340245,
		34'sd2670163,   34'sd1335088,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81
	};

	// configuration register indexes
	localparam logic [2:0] CFG_MIN_RANGE = 3'd0;
	localparam logic [2:0] CFG_MAX_RANGE = 3'd1;
	localparam logic [2:0] CFG_START_ANG = 3'd2;
	localparam logic [2:0] CFG_ANG_STEP  = 3'd3;
	localparam logic [2:0] CFG_BOX_XLO   = 3'd4;
	localparam logic [2:0] CFG_BOX_XHI   = 3'd5;
	localparam logic [2:0] CFG_BOX_YLO   = 3'd6;
	localparam logic [2:0] CFG_BOX_YHI   = 3'd7;

	typedef struct packed {
		logic [RNG_W-1:0]        min_range;
		logic [RNG_W-1:0]        max_range;
		logic [ANG_W-1:0]        start_angle;
		logic [ANG_W-1:0]        angle_step;
		logic signed [BOX_W-1:0] box_xlo;
		logic signed [BOX_W-1:0] box_xhi;
		logic signed [BOX_W-1:0] box_ylo;
		logic signed [BOX_W-1:0] box_yhi;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		min_range:   16'd0,
		max_range:   16'd65535,
		start_angle: 16'd0,
		angle_step:  16'd16,
		box_xlo:     17'sd0,
		box_xhi:     17'sd0,
		box_ylo:     17'sd0,
		box_yhi:     17'sd0
	};

	// sample fields that ride along the pipeline
	typedef struct packed {
		logic [IDX_W-1:0] beam_index;
		logic [RNG_W-1:0] rng;
		logic             finite;
		logic             check;
	} side_t;

	typedef struct packed {
		side_t                side;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_t;

endpackage

[hdl/lsbf_front.sv]
// Front end: beam angle, range window check, quadrant fold and gain-scaled start vector.
// Depends on lsbf_pkg and the assertion macro header.
`include "laser_scan_box_filter_core_macros.svh"

module lsbf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsbf_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lsbf_pkg::IDX_W-1:0]  beam_index,
	input  logic [lsbf_pkg::RNG_W-1:0]  range_in,
	input  logic                        range_in_finite,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lsbf_pkg::rot_t              out_data
);
	import lsbf_pkg::*;

	logic                     vld_s1, vld_s2, vld_s3;
	logic                     en1, en2, en3;
	side_t                    side_s1, side_s2;
	logic [ANG_W-1:0]         angle_s1;
	logic [MAG_W-1:0]         mag_s2;
	logic                     neg_s2;
	logic signed [ZW-1:0]     z_s2;
	rot_t                     rot_s3;

	logic [IDX_W+ANG_W-1:0]   step_prod;
	logic [ANG_W-1:0]         angle_nx;
	logic                     check_nx;
	logic                     neg_nx;
	logic [ANG_W-1:0]         angle_fold;
	logic [PHASE_W-1:0]       phase;
	logic [MAG_W-1:0]         mag_nx;
	logic signed [XW-1:0]     mag_x;

	// a stage loads when it is empty or the stage after it moves
	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	// stage 1: angle wraps modulo one turn
	assign step_prod = beam_index * cfg.angle_step;
	assign angle_nx  = cfg.start_angle + step_prod[ANG_W-1:0];
	assign check_nx  = range_in_finite && (range_in >= cfg.min_range) &&
		(range_in <= cfg.max_range);

	// stage 2: fold second and third quadrant by half a turn
	assign neg_nx     = angle_s1[ANG_W-1] ^ angle_s1[ANG_W-2];
	assign angle_fold = {angle_s1[ANG_W-1] ^ neg_nx, angle_s1[ANG_W-2:0]};
	assign phase      = {angle_fold, {(PHASE_W-ANG_W){1'b0}}};
	assign mag_nx     = side_s1.rng * GAIN_Q30;

	// stage 3: signed start vector
	assign mag_x = {{(XW-MAG_W){1'b0}}, mag_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			side_s1.beam_index <= beam_index;
			side_s1.rng        <= range_in;
			side_s1.finite     <= range_in_finite;
			side_s1.check      <= check_nx;
			angle_s1           <= angle_nx;
		end
		if (en2) begin
			side_s2 <= side_s1;
			mag_s2  <= mag_nx;
			neg_s2  <= neg_nx;
			z_s2    <= {{(ZW-PHASE_W){phase[PHASE_W-1]}}, phase};
		end
		if (en3) begin
			rot_s3.side <= side_s2;
			rot_s3.x    <= neg_s2 ? -mag_x : mag_x;
			rot_s3.y    <= '0;
			rot_s3.z    <= z_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = rot_s3;

	`LSBF_ASSERT_NOW(a_front_ready_chain, !out_ready || in_ready, "front stalls with sink ready")
	`LSBF_ASSERT_NOW(a_front_fold_range,
		!vld_s3 || ((rot_s3.z >= -(64'sd1 <<< 30)) && (rot_s3.z < (64'sd1 <<< 30))),
		"folded phase outside first and fourth quadrant")

endmodule

[hdl/lsbf_cordic.sv]
// Rotation pipeline: one CORDIC micro-rotation per register stage.
// Depends on lsbf_pkg and the assertion macro header.
`include "laser_scan_box_filter_core_macros.svh"

module lsbf_cordic (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lsbf_pkg::rot_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output lsbf_pkg::rot_t out_data
);
	import lsbf_pkg::*;

	localparam logic signed [ZW-1:0] Z_TOL = 34'sd1024;

	logic [NROT-1:0] vld_s;
	logic [NROT-1:0] vld_prev;
	logic [NROT-1:0] en;
	rot_t            rot_s [NROT];
	rot_t            cin   [NROT];

	// stage k moves if the sink takes or any stage from k on holds a bubble
	always_comb begin
		for (int k = 0; k < NROT; k++) begin
			en[k] = out_ready | ~&(vld_s | NROT'((64'd1 << k) - 64'd1));
		end
	end

	assign vld_prev = {vld_s[NROT-2:0], in_valid};
	assign in_ready = en[0];
	assign cin[0]   = in_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NROT; k++) begin
				if (en[k]) vld_s[k] <= vld_prev[k];
			end
		end
	end

	for (genvar k = 0; k < NROT; k++) begin : g_rot
		logic signed [XW-1:0] xi, yi, dx, dy;
		logic signed [ZW-1:0] zi;
		rot_t                 nx;

		if (k > 0) begin : g_link
			assign cin[k] = rot_s[k-1];
		end

		assign xi = cin[k].x;
		assign yi = cin[k].y;
		assign zi = cin[k].z;
		assign dx = yi >>> k;
		assign dy = xi >>> k;

		always_comb begin
			nx.side = cin[k].side;
			if (!zi[ZW-1]) begin
				nx.x = xi - dx;
				nx.y = yi + dy;
				nx.z = zi - ATAN_TAB[k];
			end else begin
				nx.x = xi + dx;
				nx.y = yi - dy;
				nx.z = zi + ATAN_TAB[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) rot_s[k] <= nx;
		end
	end

	assign out_valid = vld_s[NROT-1];
	assign out_data  = rot_s[NROT-1];

	`LSBF_ASSERT_NOW(a_cordic_converged,
		!vld_s[NROT-1] || ((rot_s[NROT-1].z > -Z_TOL) && (rot_s[NROT-1].z < Z_TOL)),
		"residual angle did not converge")

endmodule

[hdl/lsbf_box.sv]
// Box test: compares the rotated point with the scaled box bounds and sets the finite flag.
// Depends on lsbf_pkg and the assertion macro header.
`include "laser_scan_box_filter_core_macros.svh"

module lsbf_box (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsbf_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lsbf_pkg::rot_t              in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lsbf_pkg::IDX_W-1:0]  beam_index_out,
	output logic [lsbf_pkg::RNG_W-1:0]  range_out,
	output logic                        range_out_finite
);
	import lsbf_pkg::*;

	logic                 vld_s1, vld_s2;
	logic                 en1, en2;
	side_t                side_s1, side_s2;
	logic                 in_box_s1;
	logic                 keep_s2;
	logic signed [XW-1:0] xlo, xhi, ylo, yhi;
	logic                 in_box_nx;

	// bounds in Q30 millimetres
	assign xlo = {{(XW-BOX_W-FRAC_BITS){cfg.box_xlo[BOX_W-1]}}, cfg.box_xlo,
		{FRAC_BITS{1'b0}}};
	assign xhi = {{(XW-BOX_W-FRAC_BITS){cfg.box_xhi[BOX_W-1]}}, cfg.box_xhi,
		{FRAC_BITS{1'b0}}};
	assign ylo = {{(XW-BOX_W-FRAC_BITS){cfg.box_ylo[BOX_W-1]}}, cfg.box_ylo,
		{FRAC_BITS{1'b0}}};
	assign yhi = {{(XW-BOX_W-FRAC_BITS){cfg.box_yhi[BOX_W-1]}}, cfg.box_yhi,
		{FRAC_BITS{1'b0}}};

	assign in_box_nx = (in_data.x >= xlo) && (in_data.x <= xhi) &&
		(in_data.y >= ylo) && (in_data.y <= yhi);

	assign en2      = !vld_s2 || out_ready;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			side_s1   <= in_data.side;
			in_box_s1 <= in_box_nx;
		end
		if (en2) begin
			side_s2 <= side_s1;
			// drop only samples inside the range window that land in the box
			keep_s2 <= side_s1.finite && !(side_s1.check && in_box_s1);
		end
	end

	assign out_valid        = vld_s2;
	assign beam_index_out   = side_s2.beam_index;
	assign range_out        = side_s2.rng;
	assign range_out_finite = keep_s2;

	`LSBF_ASSERT_NOW(a_box_unchecked_pass,
		!vld_s2 || side_s2.check || (keep_s2 == side_s2.finite),
		"sample outside range window was altered")

endmodule

[hdl/laser_scan_box_filter_core.sv]
// Laser scan box filter top level: configuration registers and the three pipeline sections.
// Depends on lsbf_pkg, lsbf_front, lsbf_cordic and lsbf_box.
//
// Use:
//   Samples enter on the in_valid/in_ready channel (beam_index, range_in,
//   range_in_finite) and leave on out_valid/out_ready in the same order, one
//   result per sample. Index and range pass unchanged; range_out_finite drops
//   to 0 for non-finite samples and for in-window samples whose point lies in
//   the box.
//   Configuration: cfg_valid/cfg_ready with cfg_index (register 0..7) and
//   cfg_data; cfg_ready is always high. Write only while no sample is in flight.
//   Throughput: one sample per clock while out_ready is high. A sample reaches
//   out_valid through 3 front stages (angle multiply, gain multiply, fold),
//   24 CORDIC rotation stages and 2 box compare stages.
//   Reset clears every stage valid and loads the register defaults.
//   When the receiver stalls, samples collect in empty stages; in_ready falls
//   only once all 29 stages hold a sample, and nothing is lost or repeated.
module laser_scan_box_filter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [lsbf_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lsbf_pkg::IDX_W-1:0]  beam_index,
	input  logic [lsbf_pkg::RNG_W-1:0]  range_in,
	input  logic                        range_in_finite,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lsbf_pkg::IDX_W-1:0]  beam_index_out,
	output logic [lsbf_pkg::RNG_W-1:0]  range_out,
	output logic                        range_out_finite
);
	import lsbf_pkg::*;

	cfg_t cfg_q;
	logic front_valid, front_ready;
	rot_t front_data;
	logic rot_valid, rot_ready;
	rot_t rot_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MIN_RANGE: cfg_q.min_range   <= cfg_data[RNG_W-1:0];
				CFG_MAX_RANGE: cfg_q.max_range   <= cfg_data[RNG_W-1:0];
				CFG_START_ANG: cfg_q.start_angle <= cfg_data[ANG_W-1:0];
				CFG_ANG_STEP:  cfg_q.angle_step  <= cfg_data[ANG_W-1:0];
				CFG_BOX_XLO:   cfg_q.box_xlo     <= cfg_data[BOX_W-1:0];
				CFG_BOX_XHI:   cfg_q.box_xhi     <= cfg_data[BOX_W-1:0];
				CFG_BOX_YLO:   cfg_q.box_ylo     <= cfg_data[BOX_W-1:0];
				CFG_BOX_YHI:   cfg_q.box_yhi     <= cfg_data[BOX_W-1:0];
				default:       cfg_q             <= cfg_q;
			endcase
		end
	end

	lsbf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.beam_index      (beam_index),
		.range_in        (range_in),
		.range_in_finite (range_in_finite),
		.out_valid       (front_valid),
		.out_ready       (front_ready),
		.out_data        (front_data)
	);

	lsbf_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (rot_valid),
		.out_ready (rot_ready),
		.out_data  (rot_data)
	);

	lsbf_box u_box (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.in_valid         (rot_valid),
		.in_ready         (rot_ready),
		.in_data          (rot_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.beam_index_out   (beam_index_out),
		.range_out        (range_out),
		.range_out_finite (range_out_finite)
	);

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for laser_scan_box_filter_core: streams range samples through the
// filter and checks every result against a CORDIC box predictor kept in the bench.
// Depends on lsbf_pkg and laser_scan_box_filter_core.
module tb;
	import lsbf_pkg::*;

	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_SAMPLES  = 150;
	localparam int MAX_REPORTS    = 50;

	typedef struct packed {
		logic [IDX_W-1:0] beam;
		logic [RNG_W-1:0] rng;
		logic             finite;
	} scan_sample_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [2:0]       cfg_index = CFG_MIN_RANGE;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [IDX_W-1:0] beam_index = '0;
	logic [RNG_W-1:0] range_in = '0;
	logic             range_in_finite = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [IDX_W-1:0] beam_index_out;
	logic [RNG_W-1:0] range_out;
	logic             range_out_finite;

	cfg_t         filter_regs = CFG_RESET;
	scan_sample_t scan_samples[$];
	scan_sample_t filtered_samples[$];
	logic         in_acc = 1'b0;
	logic         out_acc = 1'b0;
	logic         hold_input = 1'b0;
	int           in_gap_max = 0;
	int           out_stall_max = 0;
	int           in_wait = 0;
	int           out_stall_left = 0;
	int           idle_cycles = 0;
	int           mismatch_cnt = 0;
	int           checked_cnt = 0;
	int           removed_cnt = 0;
	int           reg_writes = 0;
	int           phase_scale [RANDOM_PHASES] = '{255, 2047, 65535, 4095, 65535, 511, 16383, 65535};

	laser_scan_box_filter_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.beam_index      (beam_index),
		.range_in        (range_in),
		.range_in_finite (range_in_finite),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.beam_index_out  (beam_index_out),
		.range_out       (range_out),
		.range_out_finite(range_out_finite)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// 1 if the sample survives the box, 0 if it is non-finite or in the range window with its point inside
	function automatic logic box_keep(scan_sample_t s);
		longint            px, py, pz, dx, dy, one;
		logic [ANG_W-1:0]  ang;
		logic [PHASE_W-1:0] phase;
		int                k;
		if (!s.finite)
			return 1'b0;
		if (s.rng < filter_regs.min_range || s.rng > filter_regs.max_range)
			return 1'b1;
		ang = filter_regs.start_angle + s.beam * filter_regs.angle_step;
		phase = {ang, {(PHASE_W - ANG_W){1'b0}}};
		px = longint'(s.rng) * longint'(GAIN_Q30);
		py = 0;
		// fold quadrants two and three onto the right half plane
		if (phase[31:30] == 2'b01 || phase[31:30] == 2'b10) begin
			px = -px;
			phase = phase + 32'h8000_0000;
		end
		pz = longint'($signed(phase));
		for (k = 0; k < NROT; k++) begin
			dx = py >>> k;
			dy = px >>> k;
			if (pz >= 0) begin
				px = px - dx;
				py = py + dy;
				pz = pz - ATAN_TAB[k];
			end else begin
				px = px + dx;
				py = py - dy;
				pz = pz + ATAN_TAB[k];
			end
		end
		one = longint'(1) <<< FRAC_BITS;
		if (px >= longint'(filter_regs.box_xlo) * one && px <= longint'(filter_regs.box_xhi) * one &&
				py >= longint'(filter_regs.box_ylo) * one && py <= longint'(filter_regs.box_yhi) * one)
			return 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t ns: %s mismatch: got %0d, want %0d", $time, field, got, want);
	endtask

	// predict on every input transfer, check on every output transfer
	always @(posedge clk) begin
		scan_sample_t taken, want;
		if (arst_n) begin
			in_acc <= in_valid && in_ready;
			out_acc <= out_valid && out_ready;
			if (in_valid && in_ready) begin
				taken = '{beam_index, range_in, range_in_finite};
				want = taken;
				want.finite = box_keep(taken);
				if (taken.finite && !want.finite)
					removed_cnt++;
				filtered_samples.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (filtered_samples.size() == 0) begin
					report_mismatch("result with no sample pending, beam_index_out",
						beam_index_out, -1);
				end else begin
					want = filtered_samples.pop_front();
					checked_cnt++;
					if (beam_index_out !== want.beam)
						report_mismatch("beam_index_out", beam_index_out, want.beam);
					if (range_out !== want.rng)
						report_mismatch("range_out", range_out, want.rng);
					if (range_out_finite !== want.finite)
						report_mismatch("range_out_finite", range_out_finite, want.finite);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
				$display("** laser_scan_box_filter_core: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// sample driver: hold until transfer, then wait a drawn gap before the next one
	always @(negedge clk) begin
		scan_sample_t nxt;
		if (arst_n && !(in_valid && !in_acc)) begin
			if (in_wait > 0) begin
				in_wait = in_wait - 1;
				in_valid <= 1'b0;
			end else if (!hold_input && scan_samples.size() > 0) begin
				nxt = scan_samples.pop_front();
				beam_index <= nxt.beam;
				range_in <= nxt.rng;
				range_in_finite <= nxt.finite;
				in_valid <= 1'b1;
				in_wait = $urandom_range(0, in_gap_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: stall a drawn number of cycles after each transfer
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_acc)
				out_stall_left = $urandom_range(0, out_stall_max);
			if (out_stall_left > 0) begin
				out_stall_left = out_stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_MIN_RANGE: filter_regs.min_range = val[RNG_W-1:0];
			CFG_MAX_RANGE: filter_regs.max_range = val[RNG_W-1:0];
			CFG_START_ANG: filter_regs.start_angle = val[ANG_W-1:0];
			CFG_ANG_STEP:  filter_regs.angle_step = val[ANG_W-1:0];
			CFG_BOX_XLO:   filter_regs.box_xlo = val;
			CFG_BOX_XHI:   filter_regs.box_xhi = val;
			CFG_BOX_YLO:   filter_regs.box_ylo = val;
			CFG_BOX_YHI:   filter_regs.box_yhi = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// 16-bit register value with a random unused top bit
	function automatic logic [CFG_W-1:0] reg16(input int v);
		return {1'($urandom_range(0, 1)), 16'(v)};
	endfunction

	task automatic set_regs(input int rmin, input int rmax, input int start, input int step,
			input int xlo, input int xhi, input int ylo, input int yhi);
		write_reg(CFG_MIN_RANGE, reg16(rmin));
		write_reg(CFG_MAX_RANGE, reg16(rmax));
		write_reg(CFG_START_ANG, reg16(start));
		write_reg(CFG_ANG_STEP, reg16(step));
		write_reg(CFG_BOX_XLO, xlo[CFG_W-1:0]);
		write_reg(CFG_BOX_XHI, xhi[CFG_W-1:0]);
		write_reg(CFG_BOX_YLO, ylo[CFG_W-1:0]);
		write_reg(CFG_BOX_YHI, yhi[CFG_W-1:0]);
	endtask

	task automatic add_sample(input int beam, input int rng, input logic fin);
		scan_sample_t s;
		s = '{12'(beam), 16'(rng), fin};
		scan_samples.push_back(s);
	endtask

	// drain the pipeline before touching registers
	task automatic settle();
		while (scan_samples.size() != 0 || in_valid || filtered_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int rand_coord(input int scale);
		return int'($urandom_range(0, 2 * scale)) - scale;
	endfunction

	task automatic random_phase(input int scale, input bit pause);
		int           rmin, rmax, xa, xb, ya, yb, tmp, step, k, pick;
		int           base;
		scan_sample_t s;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			rmin = $urandom_range(20000, 65535);
			rmax = $urandom_range(0, rmin - 1);
		end else if (pick < 3) begin
			rmin = 0;
			rmax = 65535;
		end else begin
			rmin = $urandom_range(0, scale / 4);
			rmax = $urandom_range(scale / 2, 65535);
		end
		xa = rand_coord(scale);
		xb = rand_coord(scale);
		ya = rand_coord(scale);
		yb = rand_coord(scale);
		// keep most boxes well ordered, leave some inverted
		if ($urandom_range(0, 9) != 0 && xa > xb) begin
			tmp = xa; xa = xb; xb = tmp;
		end
		if ($urandom_range(0, 9) != 0 && ya > yb) begin
			tmp = ya; ya = yb; yb = tmp;
		end
		step = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 65535);
		set_regs(rmin, rmax, $urandom_range(0, 65535), step, xa, xb, ya, yb);
		case ($urandom_range(0, 2))
			0: begin in_gap_max = 0; out_stall_max = 0; end
			1: begin in_gap_max = 6; out_stall_max = 6; end
			default: begin
				in_gap_max = $urandom_range(0, 6);
				out_stall_max = $urandom_range(0, 6);
			end
		endcase
		base = $urandom_range(0, 4095);
		for (k = 0; k < PHASE_SAMPLES; k++) begin
			if ($urandom_range(0, 9) < 7)
				s.beam = 12'(base + k);
			else
				s.beam = 12'($urandom());
			if ($urandom_range(0, 9) == 0)
				s.rng = 16'($urandom());
			else
				s.rng = 16'($urandom_range(0, scale));
			s.finite = ($urandom_range(0, 9) != 0);
			scan_samples.push_back(s);
		end
		if (pause) begin
			while (scan_samples.size() > PHASE_SAMPLES / 2)
				@(posedge clk);
			hold_input = 1'b1;
			while (in_valid || filtered_samples.size() != 0)
				@(posedge clk);
			hold_input = 1'b0;
		end
		settle();
	endtask

	initial begin
		int p;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		in_gap_max = 2;
		out_stall_max = 2;

		// reset settings: point box at the origin
		add_sample(0, 0, 1'b1);
		add_sample(4095, 65535, 1'b1);
		add_sample(0, 0, 1'b0);
		add_sample(2048, 65535, 1'b0);
		settle();

		// quarter turn per beam, 2 m box around the sensor, range window edges
		set_regs(100, 60000, 0, 16384, -1000, 1000, -1000, 1000);
		add_sample(0, 99, 1'b1);
		add_sample(0, 100, 1'b1);
		add_sample(1, 500, 1'b1);
		add_sample(2, 999, 1'b1);
		add_sample(3, 1500, 1'b1);
		add_sample(4095, 60000, 1'b1);
		add_sample(5, 60001, 1'b1);
		add_sample(6, 500, 1'b0);
		settle();

		// inverted x bounds, widest y bounds, largest angles
		set_regs(0, 65535, 65535, 65535, 1000, -1000, -65536, 65535);
		add_sample(0, 10, 1'b1);
		add_sample(4095, 65535, 1'b1);
		add_sample(1, 0, 1'b1);
		settle();

		// widest box with inverted range limits
		set_regs(65535, 0, 0, 0, -65536, 65535, -65536, 65535);
		add_sample(7, 1000, 1'b1);
		add_sample(100, 65535, 1'b1);
		add_sample(100, 0, 1'b1);
		settle();

		// widest box, every beam at half a turn
		set_regs(0, 65535, 32768, 0, -65536, 65535, -65536, 65535);
		add_sample(4095, 65535, 1'b1);
		add_sample(0, 0, 1'b1);
		add_sample(1234, 40000, 1'b0);
		settle();

		// one-millimetre range window
		write_reg(CFG_MIN_RANGE, reg16(12345));
		write_reg(CFG_MAX_RANGE, reg16(12345));
		add_sample(17, 12345, 1'b1);
		add_sample(18, 12344, 1'b1);
		add_sample(19, 12346, 1'b1);
		settle();

		for (p = 0; p < RANDOM_PHASES; p++)
			random_phase(phase_scale[p], p == 2);

		$display("Checked %0d samples, %0d removed inside the box, over %0d register writes",
			checked_cnt, removed_cnt, reg_writes);
		$display("Mismatches: %0d", mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("** laser_scan_box_filter_core: PASSED **");
		else
			$display("** laser_scan_box_filter_core: FAILED **");
		$finish;
	end

endmodule
